// ===== rtl/ics_pkg.sv =====
// ----------------------------------------------------------------------------
// ics_pkg
// shared types and constants for the interval class statistics block
// ----------------------------------------------------------------------------
package ics_pkg;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_FINISH = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_BELOW = 2'd0,
        KIND_CLASS = 2'd1,
        KIND_ABOVE = 2'd2
    } t_kind;

    localparam logic [1:0] REG_CLASS_COUNT   = 2'd0;
    localparam logic [1:0] REG_STAT_MODE     = 2'd1;
    localparam logic [1:0] REG_INCLUDE_BELOW = 2'd2;
    localparam logic [1:0] REG_INCLUDE_ABOVE = 2'd3;

    localparam int SUM_W = 64;
    localparam int DIV_W = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_BINS,
        ST_EMIT,
        ST_DIV,
        ST_OUT
    } t_state;

    // request to the shared divider
    typedef struct packed {
        logic             start;
        logic             neg;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
    } t_div_rsp;

endpackage

// ===== rtl/ics_divider.sv =====
// ----------------------------------------------------------------------------
// ics_divider
// restoring divider, one quotient bit per cycle, sign fix at the end
// ----------------------------------------------------------------------------
module ics_divider
    import ics_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    localparam int CW = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] r_quo, n_quo;
    logic [DIV_W:0]   r_rem, n_rem;
    logic [DIV_W-1:0] r_den;
    logic             r_neg;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_busy, n_busy, r_done, n_done;
    logic [DIV_W:0]   w_sh, w_sub;

    always_comb begin
        w_sh   = {r_rem[DIV_W-1:0], r_quo[DIV_W-1]};
        w_sub  = w_sh - {1'b0, r_den};
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_quo  = i_req.num;
            n_rem  = '0;
            n_cnt  = CW'(DIV_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_sub[DIV_W]) begin
                n_rem = w_sub;
                n_quo = {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_quo = {r_quo[DIV_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_req.start) begin
            r_den <= i_req.den;
            r_neg <= i_req.neg;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_neg ? (~r_quo + DIV_W'(1)) : r_quo;
endmodule

// ===== rtl/interval_class_statistics.sv =====
// ----------------------------------------------------------------------------
// interval_class_statistics
// histogram over loadable class intervals with per-class mean or proportion
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  in      | i_valid / o_stall     | i_operation .. i_sample_skip
//  out     | o_valid / i_stall     | o_slot_kind .. o_last_slot
//  cfg     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  load: written into the class table while idle. sample: one class per cycle
//  through the shared comparator, then the below/above bin update. finish: per
//  slot one pass of the shared serial divider plus the output transfer.
//  o_stall is high whenever an item is in progress; synchronous reset restores
//  the default class table and clears the accumulators; a stalled result holds.
module interval_class_statistics
    import ics_pkg::*;
#(
    parameter int NUM_CLASSES = 16,
    parameter int COUNT_WIDTH = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [3:0]  i_class_slot,
    input  logic signed [31:0] i_lower_bound,
    input  logic signed [31:0] i_upper_bound,
    input  logic        i_lower_defined,
    input  logic        i_upper_defined,
    input  logic        i_lower_inclusive,
    input  logic        i_upper_inclusive,
    input  logic signed [31:0] i_sample_value,
    input  logic        i_sample_skip,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_slot_kind,
    output logic [3:0]  o_class_number,
    output logic signed [31:0] o_stat_value,
    output logic        o_stat_missing,
    output logic        o_last_slot,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam int IW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int CIW = $clog2(NUM_CLASSES + 1);
    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

    // configuration registers
    logic [4:0] r_class_count;
    logic       r_stat_mode, r_inc_below, r_inc_above;

    // class table, valid bit marks a loaded entry, else default bounds apply
    logic [31:0] r_lo [NUM_CLASSES];
    logic [31:0] r_hi [NUM_CLASSES];
    logic [3:0]  r_fl [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] r_loaded;

    // accumulators
    logic [COUNT_WIDTH-1:0] r_cnt [NUM_CLASSES];
    logic [SUM_W-1:0]       r_sum [NUM_CLASSES];
    logic [COUNT_WIDTH-1:0] r_bcnt, r_acnt, r_act;
    logic [SUM_W-1:0]       r_bsum, r_asum;

    t_state r_state, n_state;
    logic [IW-1:0] r_idx;
    logic [1:0]    r_kind;
    logic          r_found, r_have_low;
    logic signed [31:0] r_zmin, r_val;
    logic [CIW-1:0] w_n;

    // output register
    logic        r_ovalid, r_last, r_miss;
    logic [1:0]  r_okind;
    logic [3:0]  r_ocls;
    logic [31:0] r_oval;

    t_div_req w_req;
    t_div_rsp w_rsp;

    ics_divider u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    always_comb begin
        if (r_class_count == 5'd0) w_n = CIW'(1);
        else if (32'(r_class_count) > NUM_CLASSES) w_n = CIW'(NUM_CLASSES);
        else w_n = CIW'(r_class_count);
    end

    // current class bounds, default table when never loaded
    logic signed [31:0] w_lo, w_hi;
    logic [3:0] w_fl;
    logic w_in, w_lo_ok, w_hi_ok;
    always_comb begin
        if (r_loaded[r_idx]) begin
            w_lo = r_lo[r_idx];
            w_hi = r_hi[r_idx];
            w_fl = r_fl[r_idx];
        end else begin
            w_lo = {16'(r_idx), 16'h8000};
            w_hi = {16'(r_idx) + 16'd1, 16'h8000};
            w_fl = 4'b0111;
        end
        w_lo_ok = !w_fl[0] || (w_fl[2] ? !(r_val < w_lo) : (r_val > w_lo));
        w_hi_ok = !w_fl[1] || (w_fl[3] ? !(r_val > w_hi) : (r_val < w_hi));
        w_in = w_lo_ok && w_hi_ok;
    end

    // slot being emitted
    logic [COUNT_WIDTH-1:0] w_scnt;
    logic [SUM_W-1:0]       w_ssum;
    always_comb begin
        unique case (r_kind)
            KIND_BELOW: begin w_scnt = r_bcnt; w_ssum = r_bsum; end
            KIND_ABOVE: begin w_scnt = r_acnt; w_ssum = r_asum; end
            default:    begin w_scnt = r_cnt[r_idx]; w_ssum = r_sum[r_idx]; end
        endcase
    end

    logic w_last_cls;
    assign w_last_cls = (CIW'(r_idx) == w_n - CIW'(1));
    logic w_in_acc;
    assign w_in_acc = i_valid && !o_stall;

    always_comb begin
        n_state = r_state;
        w_req.start = 1'b0;
        w_req.neg   = 1'b0;
        w_req.num   = '0;
        w_req.den   = '0;
        unique case (r_state)
            ST_IDLE: if (w_in_acc) begin
                if (t_op'(i_operation) == OP_SAMPLE && !i_sample_skip) n_state = ST_SCAN;
                else if (t_op'(i_operation) == OP_FINISH) n_state = ST_EMIT;
            end
            ST_SCAN: if (w_last_cls) n_state = ST_BINS;
            ST_BINS: n_state = ST_IDLE;
            ST_EMIT: begin
                n_state = ST_DIV;
                w_req.start = 1'b1;
                if (r_stat_mode) begin
                    w_req.num = DIV_W'({w_scnt, 16'h0});
                    w_req.den = DIV_W'(r_act);
                end else begin
                    w_req.neg = w_ssum[SUM_W-1];
                    w_req.num = w_ssum[SUM_W-1] ? (~w_ssum + SUM_W'(1)) : w_ssum;
                    w_req.den = DIV_W'(w_scnt);
                end
            end
            ST_DIV: if (w_rsp.done) n_state = ST_OUT;
            ST_OUT: if (!r_ovalid || !i_stall) n_state = r_last ? ST_IDLE : ST_EMIT;
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);

    logic w_miss_now;
    assign w_miss_now = r_stat_mode ? (r_act == '0) : (w_scnt == '0);

    // flags of the slot in flight
    logic w_slast;
    always_comb begin
        w_slast = 1'b0;
        if (r_kind == KIND_ABOVE) w_slast = 1'b1;
        else if (r_kind == KIND_CLASS && w_last_cls && !r_inc_above) w_slast = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_class_count <= 5'd1;
            r_stat_mode <= 1'b0;
            r_inc_below <= 1'b0;
            r_inc_above <= 1'b0;
            r_loaded <= '0;
            r_ovalid <= 1'b0;
            r_last <= 1'b0;
            r_bcnt <= '0; r_acnt <= '0; r_act <= '0;
            r_bsum <= '0; r_asum <= '0;
            for (int k = 0; k < NUM_CLASSES; k++) begin
                r_cnt[k] <= '0;
                r_sum[k] <= '0;
            end
            r_idx <= '0;
            r_kind <= KIND_CLASS;
        end else begin
            r_state <= n_state;
            // a new result enters the output register as the old one leaves
            if (r_state == ST_OUT && (!r_ovalid || !i_stall)) r_ovalid <= 1'b1;
            else if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_CLASS_COUNT:   r_class_count <= i_cfg_data[4:0];
                    REG_STAT_MODE:     r_stat_mode <= i_cfg_data[0];
                    REG_INCLUDE_BELOW: r_inc_below <= i_cfg_data[0];
                    default:           r_inc_above <= i_cfg_data[0];
                endcase
            end
            unique case (r_state)
                ST_IDLE: if (w_in_acc) begin
                    r_idx <= '0;
                    r_found <= 1'b0;
                    r_have_low <= 1'b0;
                    r_val <= i_sample_value;
                    r_kind <= r_inc_below ? KIND_BELOW : KIND_CLASS;
                    if (t_op'(i_operation) == OP_LOAD &&
                        32'(i_class_slot) < NUM_CLASSES) begin
                        r_lo[IW'(i_class_slot)] <= i_lower_bound;
                        r_hi[IW'(i_class_slot)] <= i_upper_bound;
                        r_fl[IW'(i_class_slot)] <= {i_upper_inclusive, i_lower_inclusive,
                                                    i_upper_defined, i_lower_defined};
                        r_loaded[IW'(i_class_slot)] <= 1'b1;
                    end
                end
                ST_SCAN: begin
                    if (w_fl[0] && (!r_have_low || w_lo < r_zmin)) begin
                        r_zmin <= w_lo;
                        r_have_low <= 1'b1;
                    end
                    if (w_in) begin
                        r_found <= 1'b1;
                        if (r_cnt[r_idx] != CMAX) begin
                            r_cnt[r_idx] <= r_cnt[r_idx] + COUNT_WIDTH'(1);
                            r_sum[r_idx] <= r_sum[r_idx] + SUM_W'(r_val);
                        end
                    end
                    if (!w_last_cls) r_idx <= r_idx + IW'(1);
                end
                ST_BINS: begin
                    if (!r_found) begin
                        if (r_have_low && r_val < r_zmin) begin
                            if (r_bcnt != CMAX) begin
                                r_bcnt <= r_bcnt + COUNT_WIDTH'(1);
                                r_bsum <= r_bsum + SUM_W'(r_val);
                            end
                        end else if (r_acnt != CMAX) begin
                            r_acnt <= r_acnt + COUNT_WIDTH'(1);
                            r_asum <= r_asum + SUM_W'(r_val);
                        end
                    end
                    if (r_act != CMAX) r_act <= r_act + COUNT_WIDTH'(1);
                end
                ST_EMIT: begin
                    r_miss  <= w_miss_now;
                    r_okind <= r_kind;
                    r_ocls  <= (r_kind == KIND_CLASS) ? 4'(r_idx) : 4'd0;
                    r_last  <= w_slast;
                end
                ST_DIV: if (w_rsp.done) r_oval <= r_miss ? 32'd0 : w_rsp.quo[31:0];
                ST_OUT: if (!r_ovalid || !i_stall) begin
                    if (r_kind == KIND_BELOW) begin
                        r_kind <= KIND_CLASS;
                        r_idx <= '0;
                    end else if (r_kind == KIND_CLASS && !w_last_cls) begin
                        r_idx <= r_idx + IW'(1);
                    end else if (r_kind == KIND_CLASS) begin
                        r_kind <= KIND_ABOVE;
                    end
                    if (r_last) begin
                        r_bcnt <= '0; r_acnt <= '0; r_act <= '0;
                        r_bsum <= '0; r_asum <= '0;
                        for (int k = 0; k < NUM_CLASSES; k++) begin
                            r_cnt[k] <= '0;
                            r_sum[k] <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // result fields latched per slot; last flag travels with the result
    logic r_olast;
    logic [1:0]  r_pkind;
    logic [3:0]  r_pcls;
    logic [31:0] r_pval;
    logic        r_pmiss;
    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && (!r_ovalid || !i_stall)) begin
            r_pkind <= r_okind;
            r_pcls  <= r_ocls;
            r_pval  <= r_oval;
            r_pmiss <= r_miss;
            r_olast <= r_last;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_slot_kind    = r_pkind;
    assign o_class_number = r_pcls;
    assign o_stat_value   = r_pval;
    assign o_stat_missing = r_pmiss;
    assign o_last_slot    = r_olast;
endmodule
